### hdl/ascii_line_crc16_checker_macros.svh
// Assertion macros for the ASCII line CRC-16 checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASCII_LINE_CRC16_CHECKER_MACROS_SVH
`define ASCII_LINE_CRC16_CHECKER_MACROS_SVH

// Same-cycle implication, off while in reset
`define ALCC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ascii_line_crc16_checker: same-cycle check failed");

// Next-cycle implication, off while in reset
`define ALCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ascii_line_crc16_checker: next-cycle check failed");

`endif

### hdl/alcc_pkg.sv
// Package for the ASCII line CRC-16 checker: constants, verdict codes, result type.
// No dependencies.
package alcc_pkg;

	localparam int unsigned MAX_LINE = 512;
	// wide enough to hold MAX_LINE + 1
	localparam int unsigned LEN_W = $clog2(MAX_LINE + 2);

	localparam logic [7:0]  LF_CHAR   = 8'h0A;
	localparam logic [7:0]  CR_CHAR   = 8'h0D;
	localparam logic [7:0]  STAR_CHAR = 8'h2A;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [2:0]  CRC_DIGITS     = 3'd4;
	localparam logic [2:0]  AFTER_STAR_CAP = 3'd7;
	localparam logic [9:0]  CR_CAP         = 10'd1023;

	typedef enum logic [2:0] {
		VERDICT_CRC_OK      = 3'd0,
		VERDICT_NO_CRC_OK   = 3'd1,
		VERDICT_CRC_MISSING = 3'd2,
		VERDICT_BAD_FIELD   = 3'd3,
		VERDICT_MISMATCH    = 3'd4,
		VERDICT_TOO_LONG    = 3'd5
	} verdict_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [9:0]  line_length;
		logic [15:0] computed_crc;
		logic [15:0] received_crc;
	} res_t;

endpackage

### hdl/alcc_rx_if.sv
// Receive byte channel of the ASCII line CRC-16 checker.
// No dependencies.
interface alcc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

### hdl/alcc_res_if.sv
// Verdict channel of the ASCII line CRC-16 checker.
// Depends on alcc_pkg.
interface alcc_res_if;
	logic              valid;
	logic              ready;
	alcc_pkg::verdict_t verdict;
	logic [9:0]        line_length;
	logic [15:0]       computed_crc;
	logic [15:0]       received_crc;

	modport source (output valid, output verdict, output line_length,
		output computed_crc, output received_crc, input ready);
	modport sink (input valid, input verdict, input line_length,
		input computed_crc, input received_crc, output ready);
endinterface

### hdl/alcc_cfg_if.sv
// Configuration write channel of the ASCII line CRC-16 checker.
// No dependencies.
interface alcc_cfg_if;
	logic valid;
	logic ready;
	logic need_crc;

	modport source (output valid, output need_crc, input ready);
	modport sink (input valid, input need_crc, output ready);
endinterface

### hdl/alcc_crc8.sv
// CRC-16/CCITT-FALSE update over one byte, MSB first, eight bit steps unrolled.
// Depends on alcc_pkg.
module alcc_crc8 (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	logic [15:0] c;

	always_comb begin
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ alcc_pkg::CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

### hdl/alcc_line_tracker.sv
// Per-line state of the checker: running CRC, star snapshot, hex field, length,
// trailing CR count; builds the verdict for a newline. Depends on alcc_pkg, alcc_crc8.
module alcc_line_tracker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [7:0]     rx_byte,
	input  logic           need_crc,
	output alcc_pkg::res_t result
);

	logic [15:0]               running_crc_q, running_crc_n;
	logic [15:0]               crc_at_star_q, crc_at_star_n;
	logic                      star_seen_q, star_seen_n;
	logic [2:0]                after_star_q, after_star_n;
	logic [15:0]               hex_accum_q, hex_accum_n;
	logic                      hex_ok_q, hex_ok_n;
	logic [9:0]                pend_cr_q, pend_cr_n;
	logic [alcc_pkg::LEN_W-1:0] length_q, length_n;

	logic [15:0] crc_next;
	logic [2:0]  cas_tmp;
	logic        ok_tmp;
	logic [10:0] cas_sum;
	logic [4:0]  digit;
	logic        too_long;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 5'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 5'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 5'(c - 8'h57);
		end else begin
			v = 5'd16;
		end
		return v;
	endfunction

	alcc_crc8 u_crc8 (
		.crc_in  (running_crc_q),
		.data    (rx_byte),
		.crc_out (crc_next)
	);

	always_comb begin
		if (length_q <= alcc_pkg::LEN_W'(alcc_pkg::MAX_LINE)) begin
			length_n = length_q + 1'b1;
		end else begin
			length_n = length_q;
		end
	end

	assign digit = hex_digit(rx_byte);

	// next line state
	always_comb begin
		running_crc_n = running_crc_q;
		crc_at_star_n = crc_at_star_q;
		star_seen_n   = star_seen_q;
		after_star_n  = after_star_q;
		hex_accum_n   = hex_accum_q;
		hex_ok_n      = hex_ok_q;
		pend_cr_n     = pend_cr_q;
		cas_tmp       = after_star_q;
		ok_tmp        = hex_ok_q;
		cas_sum       = 11'(after_star_q) + 11'(pend_cr_q);
		if (rx_byte == alcc_pkg::LF_CHAR) begin
			running_crc_n = alcc_pkg::CRC_INIT;
			crc_at_star_n = alcc_pkg::CRC_INIT;
			star_seen_n   = 1'b0;
			after_star_n  = 3'd0;
			hex_accum_n   = 16'h0000;
			hex_ok_n      = 1'b1;
			pend_cr_n     = 10'd0;
		end else begin
			running_crc_n = crc_next;
			if (rx_byte == alcc_pkg::CR_CHAR) begin
				if (pend_cr_q != alcc_pkg::CR_CAP) begin
					pend_cr_n = pend_cr_q + 10'd1;
				end
			end else begin
				// CRs followed by more text belong to the checksum field
				if (pend_cr_q != 10'd0 && star_seen_q) begin
					ok_tmp = 1'b0;
					if (cas_sum > 11'(alcc_pkg::AFTER_STAR_CAP)) begin
						cas_tmp = alcc_pkg::AFTER_STAR_CAP;
					end else begin
						cas_tmp = cas_sum[2:0];
					end
				end
				pend_cr_n    = 10'd0;
				after_star_n = cas_tmp;
				hex_ok_n     = ok_tmp;
				if (rx_byte == alcc_pkg::STAR_CHAR) begin
					star_seen_n   = 1'b1;
					crc_at_star_n = running_crc_q;
					after_star_n  = 3'd0;
					hex_accum_n   = 16'h0000;
					hex_ok_n      = 1'b1;
				end else if (star_seen_q) begin
					if (digit[4]) begin
						hex_ok_n = 1'b0;
					end else if (cas_tmp < alcc_pkg::CRC_DIGITS) begin
						hex_accum_n = {hex_accum_q[11:0], digit[3:0]};
					end
					if (cas_tmp != alcc_pkg::AFTER_STAR_CAP) begin
						after_star_n = cas_tmp + 3'd1;
					end
				end
			end
		end
	end

	// verdict for a newline item
	assign too_long = length_n > alcc_pkg::LEN_W'(alcc_pkg::MAX_LINE);

	always_comb begin
		result.line_length  = 10'(32'(length_n));
		result.computed_crc = 16'h0000;
		result.received_crc = 16'h0000;
		if (too_long) begin
			result.verdict = alcc_pkg::VERDICT_TOO_LONG;
		end else if (!star_seen_q) begin
			if (need_crc) begin
				result.verdict = alcc_pkg::VERDICT_CRC_MISSING;
			end else begin
				result.verdict = alcc_pkg::VERDICT_NO_CRC_OK;
			end
		end else if (after_star_q != alcc_pkg::CRC_DIGITS || !hex_ok_q) begin
			result.verdict      = alcc_pkg::VERDICT_BAD_FIELD;
			result.computed_crc = crc_at_star_q;
		end else begin
			result.computed_crc = crc_at_star_q;
			result.received_crc = hex_accum_q;
			if (crc_at_star_q == hex_accum_q) begin
				result.verdict = alcc_pkg::VERDICT_CRC_OK;
			end else begin
				result.verdict = alcc_pkg::VERDICT_MISMATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= alcc_pkg::CRC_INIT;
			crc_at_star_q <= alcc_pkg::CRC_INIT;
			star_seen_q   <= 1'b0;
			after_star_q  <= 3'd0;
			hex_accum_q   <= 16'h0000;
			hex_ok_q      <= 1'b1;
			pend_cr_q     <= 10'd0;
			length_q      <= '0;
		end else if (fire) begin
			running_crc_q <= running_crc_n;
			crc_at_star_q <= crc_at_star_n;
			star_seen_q   <= star_seen_n;
			after_star_q  <= after_star_n;
			hex_accum_q   <= hex_accum_n;
			hex_ok_q      <= hex_ok_n;
			pend_cr_q     <= pend_cr_n;
			length_q      <= (rx_byte == alcc_pkg::LF_CHAR) ? '0 : length_n;
		end
	end

endmodule

### hdl/ascii_line_crc16_checker.sv
// ASCII line checker with CRC-16/CCITT-FALSE over the text before the last '*'.
// Depends on alcc_pkg, the alcc_*_if interfaces, alcc_line_tracker and the macros header.
//
// Takes one byte per cycle except while a newline stalls: a byte is held in an input
// register and folded into the line state by the line tracker as it leaves that register;
// the tracker's 8-bit CRC update is unrolled, so the tracker sets the one-cycle rate. Only
// newline bytes make a verdict; the verdict is loaded into an output register as its
// newline leaves the input register, and text bytes keep flowing while a verdict waits.
// A newline stalls in the input register only while an earlier verdict is still not
// taken.
// need_crc resets to 1 and is written through the cfg channel, which is always ready.
`include "ascii_line_crc16_checker_macros.svh"

module ascii_line_crc16_checker (
	input  logic       clk,
	input  logic       arst_n,
	alcc_rx_if.sink    rx,
	alcc_res_if.source res,
	alcc_cfg_if.sink   cfg
);

	logic           need_crc_q;
	logic           valid_s1;
	logic [7:0]     rx_byte_s1;
	logic           is_lf_s1;
	logic           advance;
	logic           res_valid_q;
	alcc_pkg::res_t res_q;
	alcc_pkg::res_t result;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_crc_q <= 1'b1;
		end else if (cfg.valid) begin
			need_crc_q <= cfg.need_crc;
		end
	end

	assign is_lf_s1 = rx_byte_s1 == alcc_pkg::LF_CHAR;
	// text items always move on; a newline needs a free result slot
	assign advance  = valid_s1 && (!is_lf_s1 || !res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	alcc_line_tracker u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.rx_byte  (rx_byte_s1),
		.need_crc (need_crc_q),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && is_lf_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_lf_s1) begin
			res_q <= result;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.verdict      = res_q.verdict;
	assign res.line_length  = res_q.line_length;
	assign res.computed_crc = res_q.computed_crc;
	assign res.received_crc = res_q.received_crc;

	`ALCC_ASSERT_IMP(a_text_never_stalls, valid_s1 && !is_lf_s1, advance)
	`ALCC_ASSERT_NEXT(a_newline_gives_result, advance && is_lf_s1, res.valid)
	`ALCC_ASSERT_IMP(a_too_long_no_crc, res.valid && res.verdict == alcc_pkg::VERDICT_TOO_LONG,
		res.computed_crc == 16'h0000 && res.received_crc == 16'h0000)
	`ALCC_ASSERT_IMP(a_bad_field_no_rx_crc,
		res.valid && res.verdict == alcc_pkg::VERDICT_BAD_FIELD, res.received_crc == 16'h0000)

endmodule

### tb/sv/tb_ascii_line_crc16_checker.sv
// Self-checking bench for ascii_line_crc16_checker: drives text lines, predicts each verdict.
// Depends on ascii_line_crc16_checker, alcc_pkg, alcc_rx_if, alcc_res_if and alcc_cfg_if.
`timescale 1ns / 1ps

module tb_ascii_line_crc16_checker;

	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef logic [7:0] octets_t[$];

	typedef struct {
		logic [15:0] run_crc;
		logic [15:0] star_crc;
		bit          star;
		logic [2:0]  after_star;
		logic [15:0] hex_val;
		bit          hex_good;
		logic [9:0]  cr_run;
		logic [10:0] len;
	} line_state_t;

	logic clk;
	logic arst_n;

	alcc_rx_if  rx_if();
	alcc_res_if res_if();
	alcc_cfg_if cfg_if();

	ascii_line_crc16_checker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	line_state_t    ls;
	bit             need_crc_now;
	alcc_pkg::res_t pending_verdicts[$];
	octets_t        line_q;
	bit             idle_on;
	int unsigned    error_count;
	int unsigned    cycle_count;
	int unsigned    bytes_sent;
	int unsigned    lines_sent;
	int unsigned    verdicts_checked;
	int unsigned    verdict_hits[6];
	int unsigned    stall_left;
	logic [7:0]     odd_chars[8] = '{8'h00, 8'h0D, 8'h20, 8'h2B, 8'h2D, 8'h47, 8'h67, 8'h3A};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
				pending_verdicts.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------- prediction ----------------

	function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
		crc = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			crc = crc[15] ? ((crc << 1) ^ alcc_pkg::CRC_POLY) : (crc << 1);
		return crc;
	endfunction

	// 16 marks a non-hex character
	function automatic logic [4:0] hex_nibble(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
		if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 10);
		if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 10);
		return 5'd16;
	endfunction

	function automatic logic [2:0] star_count_add(logic [2:0] c, int unsigned n);
		int unsigned s;
		s = c + n;
		return (s > alcc_pkg::AFTER_STAR_CAP) ? alcc_pkg::AFTER_STAR_CAP : 3'(s);
	endfunction

	function automatic void restart_line();
		ls.run_crc    = alcc_pkg::CRC_INIT;
		ls.star_crc   = alcc_pkg::CRC_INIT;
		ls.star       = 1'b0;
		ls.after_star = '0;
		ls.hex_val    = '0;
		ls.hex_good   = 1'b1;
		ls.cr_run     = '0;
		ls.len        = '0;
	endfunction

	function automatic void predict_line_byte(logic [7:0] b);
		alcc_pkg::res_t r;
		logic [4:0]     d;
		if (ls.len <= alcc_pkg::MAX_LINE)
			ls.len++;
		if (b != alcc_pkg::LF_CHAR) begin
			if (b == alcc_pkg::CR_CHAR) begin
				if (ls.cr_run < alcc_pkg::CR_CAP)
					ls.cr_run++;
			end else begin
				// CRs followed by more text belong to the checksum field
				if (ls.cr_run != 0 && ls.star) begin
					ls.hex_good   = 1'b0;
					ls.after_star = star_count_add(ls.after_star, ls.cr_run);
				end
				ls.cr_run = '0;
				if (b == alcc_pkg::STAR_CHAR) begin
					ls.star       = 1'b1;
					ls.star_crc   = ls.run_crc;
					ls.after_star = '0;
					ls.hex_val    = '0;
					ls.hex_good   = 1'b1;
				end else if (ls.star) begin
					d = hex_nibble(b);
					if (d > 15)
						ls.hex_good = 1'b0;
					else if (ls.after_star < alcc_pkg::CRC_DIGITS)
						ls.hex_val = {ls.hex_val[11:0], d[3:0]};
					ls.after_star = star_count_add(ls.after_star, 1);
				end
			end
			ls.run_crc = crc16_step(ls.run_crc, b);
			return;
		end
		r.computed_crc = '0;
		r.received_crc = '0;
		if (ls.len > alcc_pkg::MAX_LINE) begin
			r.verdict = alcc_pkg::VERDICT_TOO_LONG;
		end else if (!ls.star) begin
			if (need_crc_now)
				r.verdict = alcc_pkg::VERDICT_CRC_MISSING;
			else
				r.verdict = alcc_pkg::VERDICT_NO_CRC_OK;
		end else if (ls.after_star != alcc_pkg::CRC_DIGITS || !ls.hex_good) begin
			r.verdict      = alcc_pkg::VERDICT_BAD_FIELD;
			r.computed_crc = ls.star_crc;
		end else begin
			r.computed_crc = ls.star_crc;
			r.received_crc = ls.hex_val;
			if (ls.star_crc == ls.hex_val)
				r.verdict = alcc_pkg::VERDICT_CRC_OK;
			else
				r.verdict = alcc_pkg::VERDICT_MISMATCH;
		end
		r.line_length = 10'(ls.len);
		pending_verdicts = {pending_verdicts, r};
		restart_line();
	endfunction

	// ---------------- checking ----------------

	task automatic flag_error(input string what, input logic [15:0] want, input logic [15:0] got);
		$display("ERROR at %0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
		error_count++;
	endtask

	always @(posedge clk) begin
		alcc_pkg::res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (res_if.verdict <= alcc_pkg::VERDICT_TOO_LONG)
				verdict_hits[res_if.verdict]++;
			if (pending_verdicts.size() == 0) begin
				flag_error("verdict with no line pending, verdict", '0, res_if.verdict);
			end else begin
				want = pending_verdicts.pop_front();
				verdicts_checked++;
				if (res_if.verdict !== want.verdict)
					flag_error("verdict", want.verdict, res_if.verdict);
				if (res_if.line_length !== want.line_length)
					flag_error("line_length", want.line_length, res_if.line_length);
				if (res_if.computed_crc !== want.computed_crc)
					flag_error("computed_crc", want.computed_crc, res_if.computed_crc);
				if (res_if.received_crc !== want.received_crc)
					flag_error("received_crc", want.received_crc, res_if.received_crc);
			end
		end
	end

	// verdict side back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (stall_left != 0) begin
			res_if.ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 3);
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// ---------------- driving ----------------

	// called at a falling edge; returns at a falling edge with valid still high
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			rx_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		predict_line_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic wait_all_verdicts();
		rx_if.valid <= 1'b0;
		do @(negedge clk); while (pending_verdicts.size() != 0);
	endtask

	task automatic write_need_crc(input bit v);
		wait_all_verdicts();
		// verdict path is two stages deep
		repeat (4) @(negedge clk);
		cfg_if.need_crc <= v;
		cfg_if.valid    <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		need_crc_now = v;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
		if (n < 10)
			return 8'h30 + n;
		return (lower ? 8'h61 : 8'h41) + (n - 10);
	endfunction

	function automatic void put_byte(logic [7:0] b);
		line_q = {line_q, b};
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	// appends '*' and the CRC of the line so far, xor flip to force a mismatch
	function automatic void put_star_crc(bit lower, logic [15:0] flip);
		logic [15:0] c;
		c = alcc_pkg::CRC_INIT;
		foreach (line_q[i])
			c = crc16_step(c, line_q[i]);
		c = c ^ flip;
		put_byte(alcc_pkg::STAR_CHAR);
		for (int i = 3; i >= 0; i--)
			put_byte(hex_char(c[i*4 +: 4], lower));
	endfunction

	function automatic void put_payload(int n, bit allow_star);
		logic [7:0] b;
		repeat (n) begin
			if ($urandom_range(0, 7) == 0)
				b = $urandom_range(0, 255);
			else
				b = $urandom_range(32, 126);
			if (b == alcc_pkg::LF_CHAR || (!allow_star && b == alcc_pkg::STAR_CHAR))
				b = 8'h41;
			put_byte(b);
		end
	endfunction

	task automatic send_line();
		foreach (line_q[i])
			send_byte(line_q[i]);
		line_q.delete();
		lines_sent++;
	endtask

	// ---------------- tests ----------------

	task automatic test_checksum_ok();
		put_byte(alcc_pkg::LF_CHAR);
		send_line();
		put_star_crc(1'b0, '0);
		put_text("\n");
		send_line();
		// trailing CRs are stripped
		put_text("Az09");
		put_star_crc(1'b1, '0);
		put_text("\015\015\n");
		send_line();
		// only the last star delimits the checksum
		put_text("x*y");
		put_star_crc(1'b0, '0);
		put_text("\n");
		send_line();
		// a CR inside the payload is covered by the CRC
		put_text("a\015b");
		put_star_crc(1'b1, '0);
		put_text("\n");
		send_line();
		put_byte(8'h00);
		put_byte(8'hFF);
		put_star_crc(1'b0, '0);
		put_text("\n");
		send_line();
		put_text("m");
		put_star_crc(1'b0, 16'h0001);
		put_text("\n");
		send_line();
	endtask

	task automatic test_bad_field();
		put_text("*123\n");
		send_line();
		put_text("*12345\n");
		send_line();
		put_text("*+FFF\n");
		send_line();
		put_text("* FFF\n");
		send_line();
		put_text("*0xFF\n");
		send_line();
		put_text("*12G4\n");
		send_line();
		put_text("*FF\015F\n");
		send_line();
		put_byte(alcc_pkg::STAR_CHAR);
		put_byte(8'h00);
		put_text("FFF\n");
		send_line();
		put_text("*\n");
		send_line();
	endtask

	task automatic test_no_crc_accept();
		write_need_crc(1'b0);
		put_text("hello\n");
		send_line();
		put_text("\015\n");
		send_line();
		put_text("ok");
		put_star_crc(1'b1, '0);
		put_text("\n");
		send_line();
		put_text("*zz\n");
		send_line();
		write_need_crc(1'b1);
	endtask

	task automatic test_line_limit();
		// exactly MAX_LINE bytes with the newline: still checked
		put_payload(alcc_pkg::MAX_LINE - 6, 1'b1);
		put_star_crc(1'b0, '0);
		put_text("\n");
		send_line();
		// two bytes over: too long despite a good checksum, length saturates
		put_payload(alcc_pkg::MAX_LINE - 4, 1'b1);
		put_star_crc(1'b1, '0);
		put_text("\n");
		send_line();
	endtask

	task automatic random_line();
		int          kind;
		int          pos;
		int          idx;
		logic [15:0] flip;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			put_payload($urandom_range(0, 20), 1'b1);
			flip = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0;
			put_star_crc($urandom_range(0, 1), flip);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) put_byte(alcc_pkg::CR_CHAR);
		end else if (kind < 75) begin
			// well-formed field, then broken
			put_payload($urandom_range(0, 20), 1'b1);
			put_star_crc($urandom_range(0, 1), '0);
			pos = line_q.size() - $urandom_range(1, 4);
			idx = line_q.size() - 4;
			case ($urandom_range(0, 4))
				0: line_q.delete(pos);
				1: put_byte(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
				2: line_q[pos] = odd_chars[$urandom_range(0, 7)];
				3: begin
					line_q.insert(idx, 8'h78);
					line_q.insert(idx, 8'h30);
				end
				default: line_q.insert(idx, odd_chars[$urandom_range(2, 4)]);
			endcase
		end else if (kind < 85) begin
			put_payload($urandom_range(0, 20), 1'b0);
		end else if (kind < 95) begin
			repeat ($urandom_range(1, 30)) put_byte($urandom_range(0, 255));
		end else begin
			repeat ($urandom_range(0, 2)) put_byte(alcc_pkg::CR_CHAR);
		end
		put_byte(alcc_pkg::LF_CHAR);
		send_line();
	endtask

	task automatic test_random_traffic();
		int unsigned phase_end;
		for (int p = 0; p < 4; p++) begin
			write_need_crc((p == 2) ? 1'($urandom_range(0, 1)) : 1'(p));
			if (p == 3)
				idle_on = 1'b0;
			phase_end = bytes_sent + 30;
			while (bytes_sent < phase_end) begin
				random_line();
				if ($urandom_range(0, 24) == 0)
					wait_all_verdicts();
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		rx_if.valid     = 1'b0;
		rx_if.rx_byte   = '0;
		res_if.ready    = 1'b0;
		cfg_if.valid    = 1'b0;
		cfg_if.need_crc = 1'b0;
		idle_on         = 1'b1;
		need_crc_now    = 1'b1;
		restart_line();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_checksum_ok();
		test_bad_field();
		test_no_crc_accept();
		test_line_limit();
		test_random_traffic();

		wait_all_verdicts();
		repeat (8) @(negedge clk);
		$display("Covered %0d bytes in %0d lines, checksum demanded and optional, %0d verdicts checked",
			bytes_sent, lines_sent, verdicts_checked);
		$display("Verdicts seen: ok %0d, unchecked %0d, missing %0d, bad field %0d,",
			verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3]);
		$display("  mismatch %0d, too long %0d", verdict_hits[4], verdict_hits[5]);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/alcc_pkg.sv
hdl/alcc_rx_if.sv
hdl/alcc_res_if.sv
hdl/alcc_cfg_if.sv
hdl/alcc_crc8.sv
hdl/alcc_line_tracker.sv
hdl/ascii_line_crc16_checker.sv
tb/sv/tb_ascii_line_crc16_checker.sv
